FILE: design/mqrr_pkg.sv
// ----------------------------------------------------------------------------
// mqrr_pkg
// Shared types and constants for the round-robin multi-queue distributor.
// ----------------------------------------------------------------------------
package mqrr_pkg;

  localparam int unsigned QUEUES    = 8;
  localparam int unsigned MAX_DEPTH = 16;
  localparam int unsigned QIDX_W    = 3;
  localparam int unsigned NQ_W      = 4;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned TOTAL_W   = 8;
  localparam int unsigned CFG_W     = 5;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  localparam logic CFG_ACTIVE_QUEUES  = 1'b0;
  localparam logic CFG_QUEUE_CAPACITY = 1'b1;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DEQ,
    S_READ,
    S_SUM,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } qtab_cmd_t;

endpackage

FILE: design/mqrr_ram.sv
// ----------------------------------------------------------------------------
// mqrr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mqrr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: design/mqrr_qtab.sv
// ----------------------------------------------------------------------------
// mqrr_qtab
// Per-queue head, tail and fill count table with push and pop updates.
// ----------------------------------------------------------------------------
module mqrr_qtab
  import mqrr_pkg::*;
#(
  parameter int unsigned PTR_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [QIDX_W-1:0] idx_i,
  input  qtab_cmd_t         cmd_i,
  input  logic [CAP_W-1:0]  cap_i,
  output logic [PTR_W-1:0]  head_o,
  output logic [PTR_W-1:0]  tail_o,
  output logic [CAP_W-1:0]  fill_o
);

  logic [PTR_W-1:0] head_q [QUEUES];
  logic [PTR_W-1:0] tail_q [QUEUES];
  logic [CAP_W-1:0] fill_q [QUEUES];

  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_nxt;

  function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p, logic [CAP_W-1:0] cap);
    logic [PTR_W:0] n;
    n = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
    if (32'(n) >= 32'(cap)) begin
      return '0;
    end
    return n[PTR_W-1:0];
  endfunction

  assign head_o   = head_q[idx_i];
  assign tail_o   = tail_q[idx_i];
  assign fill_o   = fill_q[idx_i];
  assign head_nxt = step_ptr(head_o, cap_i);
  assign tail_nxt = step_ptr(tail_o, cap_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.push) begin
      tail_q[idx_i] <= tail_nxt;
      fill_q[idx_i] <= fill_o + CAP_W'(1);
    end else if (cmd_i.pop) begin
      head_q[idx_i] <= head_nxt;
      fill_q[idx_i] <= fill_o - CAP_W'(1);
    end
  end

endmodule

FILE: design/multi_queue_round_robin_spill_top.sv
// ----------------------------------------------------------------------------
// multi_queue_round_robin_spill_top
// Round-robin distributor over eight circular tag queues with per-queue pop.
// ----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around a single
// compare/add unit that looks at one queue per cycle. An enqueue first
// subtracts the active queue count n from the cursor until the cursor is below
// it (no subtraction unless that count was lowered), then probes queues from
// the cursor until one has room or all n active queues are full, and then sums
// the stored total one queue at a time over all n active queues. A dequeue
// checks the selected queue, reads the tag when the queue is in range and not
// empty, and then sums the stored total the same way. The next request can be
// accepted while a finished result still waits on the master side. Tags live
// in a single-port RAM with registered read.
// ----------------------------------------------------------------------------
module multi_queue_round_robin_spill_top
  import mqrr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // request_tag, queue_sel, zero pad
  input  logic                 s_axis_tuser,   // action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // chosen_queue, tag_out, total_stored, zero pad
  output logic [1:0]           m_axis_tuser    // status
);

  localparam int unsigned PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned ADDR_W = QIDX_W + PTR_W;
  localparam int unsigned DEPTH  = QUEUES << PTR_W;

  logic [NQ_W-1:0]  cfg_nq_q;
  logic [CAP_W-1:0] cfg_cap_q;
  logic [NQ_W-1:0]  nq;
  logic [CAP_W-1:0] cap;

  state_e             state_q, state_d;
  logic [QIDX_W-1:0]  q_q, q_d;
  logic [NQ_W-1:0]    cnt_q, cnt_d;
  logic [QIDX_W-1:0]  cur_q, cur_d;
  logic               act_q;
  logic [TAG_W-1:0]   tag_q;
  status_e            status_q, status_d;
  logic [QIDX_W-1:0]  chosen_q, chosen_d;
  logic [TAG_W-1:0]   tagout_q, tagout_d;
  logic [TOTAL_W-1:0] acc_q, acc_d;

  logic               m_valid_q;
  status_e            m_status_q;
  logic [QIDX_W-1:0]  m_chosen_q;
  logic [TAG_W-1:0]   m_tag_q;
  logic [TOTAL_W-1:0] m_total_q;
  logic               load;

  qtab_cmd_t          cmd;
  logic [PTR_W-1:0]   head_rd;
  logic [PTR_W-1:0]   tail_rd;
  logic [CAP_W-1:0]   fill_rd;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [TAG_W-1:0]   ram_rdata;

  logic               accept;
  logic [NQ_W-1:0]    q_inc;
  logic [NQ_W-1:0]    cnt_inc;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nq_q  <= NQ_W'(QUEUES);
      cfg_cap_q <= CAP_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_QUEUES:  cfg_nq_q  <= cfg_data_i[NQ_W-1:0];
        CFG_QUEUE_CAPACITY: cfg_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_nq_q == '0) begin
      nq = NQ_W'(1);
    end else if (32'(cfg_nq_q) > QUEUES) begin
      nq = NQ_W'(QUEUES);
    end else begin
      nq = cfg_nq_q;
    end
    if (cfg_cap_q == '0) begin
      cap = CAP_W'(1);
    end else if (32'(cfg_cap_q) > MAX_DEPTH) begin
      cap = CAP_W'(MAX_DEPTH);
    end else begin
      cap = cfg_cap_q;
    end
  end

  mqrr_qtab #(
    .PTR_W (PTR_W)
  ) u_qtab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (q_q),
    .cmd_i  (cmd),
    .cap_i  (cap),
    .head_o (head_rd),
    .tail_o (tail_rd),
    .fill_o (fill_rd)
  );

  mqrr_ram #(
    .WIDTH (TAG_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (tag_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_inc         = {1'b0, q_q} + NQ_W'(1);
  assign cnt_inc       = cnt_q + NQ_W'(1);
  assign ram_addr      = (act_q == ACT_ENQ) ? {q_q, tail_rd} : {q_q, head_rd};

  // sequencer
  always_comb begin
    state_d  = state_q;
    q_d      = q_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    status_d = status_q;
    chosen_d = chosen_q;
    tagout_d = tagout_q;
    acc_d    = acc_q;
    cmd      = '0;
    ram_we   = 1'b0;
    load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          tagout_d = '0;
          if (s_axis_tuser == ACT_ENQ) begin
            q_d     = cur_q;
            state_d = S_MOD;
          end else begin
            q_d      = s_axis_tdata[TAG_W +: QIDX_W];
            chosen_d = s_axis_tdata[TAG_W +: QIDX_W];
            state_d  = S_DEQ;
          end
        end
      end
      S_MOD: begin
        if ({1'b0, q_q} >= nq) begin
          q_d = QIDX_W'({1'b0, q_q} - nq);
        end else begin
          cur_d   = (q_inc == nq) ? '0 : q_inc[QIDX_W-1:0];
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fill_rd < cap) begin
          ram_we   = 1'b1;
          cmd.push = 1'b1;
          chosen_d = q_q;
          q_d      = '0;
          acc_d    = '0;
          state_d  = S_SUM;
        end else if (cnt_inc == nq) begin
          status_d = ST_FULL;
          chosen_d = '0;
          q_d      = '0;
          acc_d    = '0;
          state_d  = S_SUM;
        end else begin
          cnt_d = cnt_inc;
          q_d   = (q_inc == nq) ? '0 : q_inc[QIDX_W-1:0];
        end
      end
      S_DEQ: begin
        if ({1'b0, q_q} >= nq) begin
          status_d = ST_BAD;
          q_d      = '0;
          acc_d    = '0;
          state_d  = S_SUM;
        end else if (fill_rd == '0) begin
          status_d = ST_EMPTY;
          q_d      = '0;
          acc_d    = '0;
          state_d  = S_SUM;
        end else begin
          cmd.pop = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        tagout_d = ram_rdata;
        q_d      = '0;
        acc_d    = '0;
        state_d  = S_SUM;
      end
      S_SUM: begin
        acc_d = acc_q + TOTAL_W'(fill_rd);
        if (q_inc == nq) begin
          state_d = S_FINISH;
        end else begin
          q_d = q_inc[QIDX_W-1:0];
        end
      end
      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      q_q     <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      q_q     <= q_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= s_axis_tuser;
      tag_q <= s_axis_tdata[TAG_W-1:0];
    end
    status_q <= status_d;
    chosen_q <= chosen_d;
    tagout_q <= tagout_d;
    acc_q    <= acc_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_status_q <= status_q;
      m_chosen_q <= chosen_q;
      m_tag_q    <= tagout_q;
      m_total_q  <= acc_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W - QIDX_W - TAG_W - TOTAL_W){1'b0}},
                          m_total_q, m_tag_q, m_chosen_q};

endmodule
